// File: hdl/adq_pkg.sv
// Shared types and constants for the array double-ended queue.
// Used by adq_ctrl and array_double_ended_queue_unit; no dependencies.
package adq_pkg;

  localparam int unsigned DEPTH        = 32;
  localparam int unsigned RESULT_LIMIT = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAP_W        = 6;
  localparam int unsigned CMD_W        = 3;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CAP_RESET    = 32;

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // signed pointer: rear spans -1..DEPTH-1, front spans 0..DEPTH
  localparam int unsigned PTR_W  = $clog2(DEPTH + 1) + 1;
  localparam int unsigned CMP_W  = ((CAP_W > PTR_W) ? CAP_W : PTR_W) + 1;
  localparam int unsigned REM_W  = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned CNT_W  = ((PTR_W > REM_W) ? PTR_W : REM_W) + 1;

  // APB map: one register at byte address 0
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_REAR  = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_DEL_REAR  = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DISPLAY   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_NOFRONT = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DEL  = 3'b010,
    ST_DISP = 3'b100
  } state_e;

  // slot memory request from the controller
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// File: hdl/adq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module adq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/adq_ctrl.sv
// Command sequencer for the deque: pointers, slot memory requests, result register.
// Depends on adq_pkg.
module adq_ctrl import adq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CAP_W-1:0]         cap_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     last_o,
  output mem_req_t                 mem_req_o,
  input  logic [DATA_W-1:0]        mem_rdata_i
);

  state_e state_q, state_d;
  logic signed [PTR_W-1:0] front_q, front_d, rear_q, rear_d;
  logic [ADDR_W-1:0] disp_addr_q, disp_addr_d;
  logic [REM_W-1:0]  remain_q, remain_d;

  logic                     out_valid_q, out_valid_d;
  logic [STAT_W-1:0]        status_q, status_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     last_q, last_d;

  logic out_free, accept, empty, full;
  logic signed [PTR_W-1:0] rear_lim, rear_inc, rear_dec, front_dec, front_inc, span;
  logic [CMP_W-1:0] cap_ext;
  logic [REM_W-1:0] disp_cnt;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign empty     = front_q > rear_q;
  assign rear_inc  = rear_q + PTR_W'(1);
  assign rear_dec  = rear_q - PTR_W'(1);
  assign front_inc = front_q + PTR_W'(1);
  assign front_dec = front_q - PTR_W'(1);
  assign span      = rear_q - front_q + PTR_W'(1);

  // last usable rear position: capacity clamped to 1..DEPTH, minus one
  assign cap_ext = CMP_W'(cap_i);
  always_comb begin
    if (cap_i == '0) begin
      rear_lim = '0;
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      rear_lim = PTR_W'(DEPTH - 1);
    end else begin
      rear_lim = PTR_W'(cap_ext - CMP_W'(1));
    end
  end
  assign full = rear_q >= rear_lim;

  // display length, capped at the result limit
  assign disp_cnt = (CNT_W'(unsigned'(span)) > CNT_W'(RESULT_LIMIT)) ?
                    REM_W'(RESULT_LIMIT) : REM_W'(unsigned'(span));

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    disp_addr_d = disp_addr_q;
    remain_d    = remain_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    last_d      = last_q;
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = rear_inc[ADDR_W-1:0];
    mem_req_o.wdata = item_value_i;
    mem_req_o.re    = 1'b0;
    mem_req_o.raddr = disp_addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_e'(command_i))
            CMD_INS_REAR: begin
              out_valid_d = 1'b1;
              value_d     = '0;
              last_d      = 1'b1;
              if (full) begin
                status_d = STAT_FULL;
              end else begin
                status_d        = STAT_OK;
                rear_d          = rear_inc;
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = rear_inc[ADDR_W-1:0];
              end
            end
            CMD_INS_FRONT: begin
              out_valid_d = 1'b1;
              value_d     = '0;
              last_d      = 1'b1;
              if (front_q == '0 && rear_q == '1) begin
                status_d        = STAT_OK;
                rear_d          = '0;
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = '0;
              end else if (front_q != '0) begin
                status_d        = STAT_OK;
                front_d         = front_dec;
                mem_req_o.we    = 1'b1;
                mem_req_o.waddr = front_dec[ADDR_W-1:0];
              end else begin
                status_d = STAT_NOFRONT;
              end
            end
            CMD_DEL_REAR: begin
              if (empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
                value_d     = '0;
                last_d      = 1'b1;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = rear_q[ADDR_W-1:0];
                state_d         = ST_DEL;
                if (front_q > rear_dec) begin
                  front_d = '0;
                  rear_d  = '1;
                end else begin
                  rear_d = rear_dec;
                end
              end
            end
            CMD_DEL_FRONT: begin
              if (empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
                value_d     = '0;
                last_d      = 1'b1;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = front_q[ADDR_W-1:0];
                front_d         = front_inc;
                state_d         = ST_DEL;
              end
            end
            CMD_DISPLAY: begin
              if (empty) begin
                out_valid_d = 1'b1;
                status_d    = STAT_EMPTY;
                value_d     = '0;
                last_d      = 1'b1;
              end else begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = front_q[ADDR_W-1:0];
                disp_addr_d     = front_q[ADDR_W-1:0] + ADDR_W'(1);
                remain_d        = disp_cnt;
                state_d         = ST_DISP;
              end
            end
            default: ;  // unknown command: no result
          endcase
        end
      end
      ST_DEL: begin
        // result register is empty here: it was free when the delete was taken
        out_valid_d = 1'b1;
        status_d    = STAT_OK;
        value_d     = mem_rdata_i;
        last_d      = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_DISP: begin
        // read data holds while the result register is blocked
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = STAT_OK;
          value_d     = mem_rdata_i;
          last_d      = (remain_q == REM_W'(1));
          if (remain_q == REM_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            mem_req_o.re    = 1'b1;
            mem_req_o.raddr = disp_addr_q;
            disp_addr_d     = disp_addr_q + ADDR_W'(1);
            remain_d        = remain_q - REM_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      rear_q      <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    disp_addr_q <= disp_addr_d;
    remain_q    <= remain_d;
    status_q    <= status_d;
    value_q     <= value_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// File: hdl/array_double_ended_queue_unit.sv
// Array deque top level: capacity register, command sequencer, slot memory.
// Depends on adq_pkg, adq_ram and adq_ctrl.
// Inserts load the result register on acceptance; deletes and displays read the
//   registered slot memory first. Throughput: one insert per cycle while
//   out_ready_i is high; a delete holds off requests until its result is loaded;
//   displays stream up to 32 results, one per cycle while out_ready_i is high.
// Reset: deque empty (front 0, rear -1), capacity 32; slot memory is not cleared.
module array_double_ended_queue_unit import adq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // APB-style configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // command requests
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CMD_W-1:0]         command_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     last_o
);

  logic [CAP_W-1:0] cap_q;
  logic             cap_sel;
  mem_req_t         mem_req;
  logic [DATA_W-1:0] mem_rdata;

  // Capacity register at word 0; other words read as zero and ignore writes.
  assign pready  = 1'b1;
  assign cap_sel = (paddr[PADDR_W-1] == 1'b0);
  assign prdata  = cap_sel ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Sequencer: owns front/rear pointers and the result register.
  adq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_o      (value_o),
    .last_o       (last_o),
    .mem_req_o    (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  // Slot storage. Writes and reads never target the same cycle, so no bypass.
  adq_ram #(
    .Width (DATA_W),
    .Depth (DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// File: dv/tb_array_double_ended_queue_unit.sv
// Self-checking testbench for array_double_ended_queue_unit: directed and random
// deque requests, APB capacity programming and a scoreboard with its own deque model.
// Depends on adq_pkg and the array_double_ended_queue_unit RTL.
`timescale 1ns / 1ps

module tb_array_double_ended_queue_unit;
  import adq_pkg::*;

  localparam logic [PADDR_W-1:0] REG_CAPACITY_ADDR = '0;  // register 0 at byte 0
  localparam logic [CMD_W-1:0]   CMD_UNUSED_FIRST  = CMD_W'(CMD_DISPLAY + 1);
  localparam logic [CMD_W-1:0]   CMD_UNUSED_LAST   = '1;
  localparam int SETTLE_CYCLES = 8;    // covers the registered read path with margin
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off

  typedef struct {
    status_e           status;
    logic [DATA_W-1:0] value;
    logic              last;
  } deque_result_t;

  // Deque model plus the queue of results it owes the DUT.
  class deque_scoreboard;
    logic [DATA_W-1:0] slots [DEPTH];
    int                front_ix;
    int                rear_ix;
    logic [CAP_W-1:0]  capacity;
    deque_result_t     awaited[$];
    int                errors;

    function new();
      front_ix = 0;
      rear_ix  = -1;
      capacity = CAP_W'(CAP_RESET);
      errors   = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    function bit holds_nothing();
      return front_ix > rear_ix;
    endfunction

    function void owe(status_e st, logic [DATA_W-1:0] val, logic lst);
      deque_result_t r;
      r.status = st;
      r.value  = val;
      r.last   = lst;
      awaited.push_back(r);
    endfunction

    // Advance the model by one accepted request and queue its results.
    function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] item);
      int usable;
      int count;
      usable = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
      case (cmd)
        CMD_INS_REAR: begin
          if (rear_ix >= usable - 1) begin
            owe(STAT_FULL, '0, 1'b1);
          end else begin
            rear_ix++;
            slots[rear_ix] = item;
            owe(STAT_OK, '0, 1'b1);
          end
        end
        CMD_INS_FRONT: begin
          if (front_ix == 0 && rear_ix == -1) begin
            rear_ix  = 0;
            slots[0] = item;
            owe(STAT_OK, '0, 1'b1);
          end else if (front_ix != 0) begin
            front_ix--;
            slots[front_ix] = item;
            owe(STAT_OK, '0, 1'b1);
          end else begin
            owe(STAT_NOFRONT, '0, 1'b1);
          end
        end
        CMD_DEL_REAR: begin
          if (holds_nothing()) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            owe(STAT_OK, slots[rear_ix], 1'b1);
            rear_ix--;
            // only a rear delete puts the pointers back home
            if (front_ix > rear_ix) begin
              front_ix = 0;
              rear_ix  = -1;
            end
          end
        end
        CMD_DEL_FRONT: begin
          if (holds_nothing()) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            owe(STAT_OK, slots[front_ix], 1'b1);
            front_ix++;
          end
        end
        CMD_DISPLAY: begin
          if (holds_nothing()) begin
            owe(STAT_EMPTY, '0, 1'b1);
          end else begin
            count = rear_ix - front_ix + 1;
            if (count > RESULT_LIMIT) count = RESULT_LIMIT;
            for (int k = 0; k < count; k++)
              owe(STAT_OK, slots[front_ix + k], k == count - 1);
          end
        end
        default: ;  // unused codes: no result, no state change
      endcase
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic [DATA_W-1:0] val, logic lst);
      deque_result_t exp_r;
      if (awaited.size() == 0) begin
        $error("result with nothing expected: status %0d value %h last %0b", st, val, lst);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        errors++;
      end
      if (val !== exp_r.value) begin
        $error("value: expected %h, got %h", exp_r.value, val);
        errors++;
      end
      if (lst !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [CMD_W-1:0]         command_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [STAT_W-1:0]        status_o;
  logic signed [DATA_W-1:0] value_o;
  logic                     last_o;

  deque_scoreboard sb = new();
  bit idle_on  = 1'b1;  // random gaps/stalls enabled; cleared for the last phase
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off

  array_double_ended_queue_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous cap: well above every request making 32 results, each with the longest stall.
  initial begin
    #5_000_000;
    $display("tb_array_double_ended_queue_unit: done, errors");
    $finish;
  end

  // Handshake monitor. Sampling at the edge sees pre-NBA values, so no races.
  // Requests are noted before results are checked; a result never shows up in
  // the cycle its request is accepted, so the order never matters for correctness.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(command_i, item_value_i);
      if (out_valid_o && out_ready_i) sb.check_result(status_o, value_o, last_o);
    end
  end

  // Result side backpressure: random stall bursts, ready stretches, and one
  // long hold-off on request. One assignment per time step by construction.
  initial begin
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // Offer one request, with an optional idle burst first; returns just after
  // the accepting edge with valid still high so back-to-back stays glitch free.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    item_value_i <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait until every owed result is back, then let the
  // pipeline settle (unused codes leave nothing to wait on).
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write of the capacity register (junk in the upper bits), then read back.
  task automatic program_capacity(input logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] word;
    word = $urandom;
    word[CAP_W-1:0] = cap;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_capacity(cap);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(cap)) begin
      $error("capacity readback: expected %h, got %h", PDATA_W'(cap), prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly random words, with the signed extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Random requests; rear_w sets the share of rear inserts (out of 96) so a
  // phase can push the deque toward full or let it drain.
  task automatic run_random(input int n, input int rear_w);
    int r;
    int band;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      end else if (r - 4 < rear_w) begin
        cmd = CMD_INS_REAR;
      end else begin
        band = (r - 4 - rear_w) * 4 / (96 - rear_w);
        case (band)
          0:       cmd = CMD_INS_FRONT;
          1:       cmd = CMD_DEL_REAR;
          2:       cmd = CMD_DEL_FRONT;
          default: cmd = CMD_DISPLAY;
        endcase
      end
      send_request(cmd, pick_value());
    end
  endtask

  // Bring the pointers home (front 0, rear -1); the model is current after a drain.
  task automatic clear_deque();
    int held;
    if (sb.holds_nothing()) begin
      if (sb.front_ix != 0) begin
        // emptied from the front: one rear insert + delete resets the pointers
        send_request(CMD_INS_REAR, pick_value());
        send_request(CMD_DEL_REAR, '0);
      end
    end else begin
      held = sb.rear_ix - sb.front_ix + 1;
      repeat (held) send_request(CMD_DEL_REAR, '0);
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    command_i    <= CMD_INS_REAR;
    item_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty deque refusals and display, front insert from the reset
    // position, refused front insert, signed extremes, front insert after
    // front deletes, emptying that ends in a front delete then a front insert, and
    // the unused command codes.
    send_request(CMD_DEL_REAR, '0);
    send_request(CMD_DEL_FRONT, '0);
    send_request(CMD_DISPLAY, '0);
    send_request(CMD_INS_FRONT, 32'h7FFF_FFFF);
    send_request(CMD_INS_FRONT, 32'h1234_5678);
    send_request(CMD_INS_REAR, 32'h8000_0000);
    send_request(CMD_INS_REAR, 32'hFFFF_FFFF);
    send_request(CMD_INS_REAR, 32'h0000_0000);
    send_request(CMD_DISPLAY, '0);
    send_request(CMD_DEL_FRONT, '0);
    send_request(CMD_DEL_FRONT, '0);
    send_request(CMD_INS_FRONT, 32'h5555_5555);
    send_request(CMD_DEL_REAR, '0);
    send_request(CMD_DEL_REAR, '0);
    send_request(CMD_DEL_FRONT, '0);
    send_request(CMD_INS_FRONT, 32'hAAAA_AAAA);
    send_request(CMD_DISPLAY, '0);
    send_request(CMD_DEL_REAR, '0);
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_request(CMD_W'(c), 32'hDEAD_BEEF);
    wait_for_results();

    // Full capacity: fill every slot, overflow, refused front insert, full
    // 32-result display, then front deletes and front re-inserts.
    program_capacity(CAP_W'(DEPTH));
    clear_deque();
    repeat (DEPTH + 1) send_request(CMD_INS_REAR, pick_value());
    send_request(CMD_INS_FRONT, pick_value());
    send_request(CMD_DISPLAY, '0);
    repeat (2) send_request(CMD_DEL_FRONT, '0);
    repeat (2) send_request(CMD_INS_FRONT, pick_value());
    send_request(CMD_DISPLAY, '0);
    run_random(30, 40);
    wait_for_results();  // sender pause until all results are in

    // Capacity dropped below the fill level: rear inserts refused, words kept.
    program_capacity(CAP_W'(3));
    run_random(35, 20);
    wait_for_results();

    // Zero acts as one slot.
    program_capacity(CAP_W'(0));
    run_random(30, 30);
    wait_for_results();

    // Out-of-range capacity acts as DEPTH; the receiver holds off for a long
    // stretch while requests keep coming, so the DUT backs up its input.
    program_capacity('1);
    hold_req = 1'b1;
    run_random(40, 45);
    wait_for_results();

    program_capacity(CAP_W'(1));
    run_random(30, 30);
    wait_for_results();

    // Last phase: random capacity, no idling on either side.
    program_capacity(CAP_W'($urandom_range(0, 63)));
    idle_on = 1'b0;
    run_random(45, 35);
    wait_for_results();

    if (sb.errors == 0) begin
      $display("tb_array_double_ended_queue_unit: done, clean");
    end else begin
      $display("tb_array_double_ended_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
